// ===== rtl/core/slpt_pkg.sv =====
// Package for the scan line position tracker: phase codes, controller states,
// register indexes, reset values and the controller/datapath command types.
// No dependencies.
`default_nettype none

package slpt_pkg;

    // Register file layout
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_MIN    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WARMUP_TICKS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_TICKS = 2'd2;

    localparam int PULSE_MIN_W = 16;
    localparam int WARMUP_W    = 16;
    localparam int ACTIVE_W    = 15;

    localparam logic [PULSE_MIN_W-1:0] PULSE_MIN_RST    = 16'd400;
    localparam logic [WARMUP_W-1:0]    WARMUP_TICKS_RST = 16'd1000;
    localparam logic [ACTIVE_W-1:0]    ACTIVE_TICKS_RST = 15'd14000;

    // Result beat fields
    localparam int LINE_W    = 8;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam logic [LINE_W-1:0] LINE_RST = 8'd55;
    localparam logic [LINE_W-1:0] LINE_SAT = 8'd255;

    // Divider: one overflow check plus one step per quotient bit
    localparam int DIV_STEPS = LINE_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_WARMUP = 2'd1,
        PH_ACTIVE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LINE,
        ST_EMIT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // take the input beat, update tracker state
        logic div_step;   // one divider step
        logic div_first;  // step is the overflow check
        logic line_wr;    // write the scaled line value
        logic emit;       // load the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;   // accepted beat recomputes the line value
        logic out_free;   // output register can take a beat
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/scan_line_position_tracker.sv =====
// Top level of the scan line position tracker: controller plus datapath.
// Depends on slpt_pkg, slpt_ctrl and slpt_dp.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_tvalid/s_tready  | s_tdata[7:0]  one timer tick
//   m_      | out | m_tvalid/m_tready  | m_tdata[15:0] one result per tick
//   cfg_    | in  | cfg_we             | cfg_addr, cfg_wdata
//
// A tick without a line update passes through accept and output load.
// A tick that recomputes the line value also passes through the divider
// steps (overflow check, then one quotient bit each) and the line write.
// Synchronous active-low reset; no clearing pass, ready the cycle after reset.
// A stalled output holds the block in its output-load step; the next tick
// is taken as soon as the result sits in the output register.
`default_nettype none

module scan_line_position_tracker #(
    parameter int TIMER_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    // input ticks
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] sweep_level, [1] data_level
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [7:0] line_value, [8] line_updated,
                                        // [9] line_indicator, [10] data_ready,
                                        // [12:11] window_phase
);
    import slpt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    slpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    slpt_dp #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // one tick in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("tick accepted while another is in flight");

    // a recomputed line value always drops the indicator
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> !m_tdata[9])
        else $error("line indicator high on a line update");

    // window phase never takes the unused code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[12:11] != 2'd3))
        else $error("bad window phase code");

    // a new result appears only after an output load
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.emit))
        else $error("result valid without an output load");

endmodule

`default_nettype wire

// ===== rtl/core/slpt_ctrl.sv =====
// Controller for the scan line position tracker: sequences accept, the
// divider steps, the line write and the output load. Depends on slpt_pkg.
`default_nettype none

module slpt_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire slpt_pkg::dp_status_t status,
    output slpt_pkg::ctrl_cmd_t     cmd
);
    import slpt_pkg::*;

    ctrl_state_t            state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   take;
    logic                   last_step;

    assign take      = s_tvalid && (state_reg == ST_IDLE);
    assign last_step = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (take) begin
                    state_next = status.need_div ? ST_DIV : ST_EMIT;
                end
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_LINE;
                end
            end
            ST_LINE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd       = '0;
        s_tready  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = take;
            end
            ST_DIV: begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
            end
            ST_LINE: begin
                cmd.line_wr = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/slpt_dp.sv =====
// Datapath for the scan line position tracker: config registers, window
// timer, pulse tracking, restoring divider and output register. Depends on slpt_pkg.
`default_nettype none

module slpt_dp #(
    parameter int TIMER_WIDTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [slpt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [slpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [slpt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire slpt_pkg::ctrl_cmd_t            cmd,
    output slpt_pkg::dp_status_t                status,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [slpt_pkg::M_TDATA_W-1:0]      m_tdata
);
    import slpt_pkg::*;

    localparam int TW = TIMER_WIDTH;
    // wide enough for pulse_min + rise and active + warmup without wrap
    localparam int PW = ((TW > 16) ? TW : 16) + 1;
    // divider width: (rise + now) << 7 and active << 8
    localparam int DW = ((TW + 8) > (ACTIVE_W + LINE_W)) ? (TW + 8) : (ACTIVE_W + LINE_W);

    // Configuration registers
    logic [PULSE_MIN_W-1:0] pulse_min_reg;
    logic [WARMUP_W-1:0]    warmup_reg;
    logic [ACTIVE_W-1:0]    active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_min_reg <= PULSE_MIN_RST;
            warmup_reg    <= WARMUP_TICKS_RST;
            active_reg    <= ACTIVE_TICKS_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_PULSE_MIN:    pulse_min_reg <= cfg_wdata[PULSE_MIN_W-1:0];
                CFG_WARMUP_TICKS: warmup_reg    <= cfg_wdata[WARMUP_W-1:0];
                CFG_ACTIVE_TICKS: active_reg    <= cfg_wdata[ACTIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // Tracker state
    phase_t            phase_reg, phase_next;
    logic [TW-1:0]     tick_reg, tick_next;
    logic [TW-1:0]     cmp_reg, cmp_next;
    logic [TW-1:0]     rise_reg, rise_next;
    logic              prev_sweep_reg, prev_data_reg;
    logic              found_reg, found_next;
    logic              armed_reg, armed_next;
    logic              ind_reg, ind_next;
    logic              rdy_reg, rdy_next;
    logic [LINE_W-1:0] line_reg;

    // Beat decode and per-tick update
    logic              sweep, data, sweep_chg;
    logic [TW-1:0]     now;
    phase_t            phase1;
    logic [TW-1:0]     cmp1, rise1;
    logic              found1, armed1, ind1;
    logic              edge_hit, rising, falling, wide, need_div;
    logic [PW-1:0]     pulse_end, win_sum;
    logic [TW:0]       mid;

    assign sweep     = s_tdata[0];
    assign data      = s_tdata[1];
    assign now       = tick_reg;
    assign sweep_chg = (sweep != prev_sweep_reg);

    always_comb begin
        // sweep change restarts the window
        phase1 = sweep_chg ? PH_WARMUP : phase_reg;
        cmp1   = sweep_chg ? TW'(warmup_reg) : cmp_reg;
        found1 = sweep_chg ? 1'b0 : found_reg;
        rise1  = sweep_chg ? '0 : rise_reg;
        ind1   = sweep_chg ? 1'b0 : ind_reg;
        armed1 = sweep_chg ? 1'b1 : armed_reg;

        // data edges inside the armed active phase
        edge_hit  = (data != prev_data_reg) && (phase1 == PH_ACTIVE) && armed1;
        rising    = edge_hit && data;
        falling   = edge_hit && !data;
        pulse_end = PW'(pulse_min_reg) + PW'(rise1);
        wide      = (PW'(now) >= pulse_end);
        need_div  = rising && found1;
        mid       = (TW + 1)'(rise1) + (TW + 1)'(now);

        rise_next  = rising ? now : rise1;
        found_next = (falling && wide) ? 1'b1 : found1;
        armed_next = need_div ? 1'b0 : armed1;
        ind_next   = need_div ? 1'b0 : ((falling && wide) ? 1'b1 : ind1);
        rdy_next   = need_div ? 1'b0 : rdy_reg;

        // window timer
        phase_next = phase1;
        cmp_next   = cmp1;
        win_sum    = PW'(active_reg) + PW'(warmup_reg);
        if (sweep_chg) begin
            tick_next = '0;
        end else if (now == cmp1) begin
            tick_next = '0;
            priority if (phase1 == PH_WARMUP) begin
                cmp_next   = win_sum[TW-1:0];
                phase_next = PH_ACTIVE;
            end else if (phase1 == PH_ACTIVE) begin
                phase_next = PH_WAIT;
                if (found_next) begin
                    rdy_next = 1'b1;
                end
            end else begin
                // wait stays wait
                phase_next = phase1;
            end
        end else begin
            tick_next = now + 1'b1;
        end
    end

    assign status.need_div = need_div;
    assign status.out_free = !m_tvalid || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_WAIT;
            tick_reg       <= '0;
            cmp_reg        <= '1;
            rise_reg       <= '0;
            prev_sweep_reg <= 1'b0;
            prev_data_reg  <= 1'b0;
            found_reg      <= 1'b0;
            armed_reg      <= 1'b1;
            ind_reg        <= 1'b0;
            rdy_reg        <= 1'b0;
        end else if (cmd.accept) begin
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            cmp_reg        <= cmp_next;
            rise_reg       <= rise_next;
            prev_sweep_reg <= sweep;
            prev_data_reg  <= data;
            found_reg      <= found_next;
            armed_reg      <= armed_next;
            ind_reg        <= ind_next;
            rdy_reg        <= rdy_next;
        end
    end

    // Restoring divider: first step checks for quotient overflow, then one
    // quotient bit per step with the divisor shifting right
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     dvs_reg;
    logic [LINE_W-1:0] quo_reg;
    logic              sat_reg;
    logic              sweep_pend_reg;
    logic              upd_pend_reg;
    logic              ge;
    logic [LINE_W-1:0] scaled, line_new;

    assign ge       = (rem_reg >= dvs_reg);
    assign scaled   = sat_reg ? LINE_SAT : quo_reg;
    assign line_new = sweep_pend_reg ? ~scaled : scaled;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rem_reg        <= DW'({mid, 7'b0});
            dvs_reg        <= DW'({active_reg, 8'b0});
            quo_reg        <= '0;
            sat_reg        <= 1'b0;
            sweep_pend_reg <= sweep;
            upd_pend_reg   <= need_div;
        end else if (cmd.div_step) begin
            dvs_reg <= dvs_reg >> 1;
            if (cmd.div_first) begin
                sat_reg <= ge;
            end else begin
                if (ge) begin
                    rem_reg <= rem_reg - dvs_reg;
                end
                quo_reg <= {quo_reg[LINE_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg <= LINE_RST;
        end else if (cmd.line_wr) begin
            line_reg <= line_new;
        end
    end

    // Output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {3'b0, phase_reg, rdy_reg, ind_reg, upd_pend_reg, line_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
